[design/brmap_pkg.sv]
// ----------------------------------------------------------------------------
// brmap_pkg
// Shared types, constants and helper functions for the button remapper.
// ----------------------------------------------------------------------------
package brmap_pkg;

    // Lane and key geometry
    localparam int SOURCE_COUNT = 16;
    localparam int KEY_W        = 32;
    localparam int TARGET_W     = 5;
    localparam int MODE_W       = 2;
    localparam int COUNT_W      = 5;
    localparam int BUTTON_W     = 12;
    localparam int STICK_W      = 8;

    // Stick thresholds
    localparam logic [STICK_W-1:0] STICK_LOW  = 8'd43;
    localparam logic [STICK_W-1:0] STICK_HIGH = 8'd211;

    // Button positions used by the menu chord
    localparam int BTN_LTRIG  = 8;
    localparam int BTN_SELECT = 10;
    localparam int MENU_BIT   = 31;

    // Register indexes (byte address is 8 * index)
    localparam logic [2:0] REG_MAP_ENABLE   = 3'd0;
    localparam logic [2:0] REG_STICK_ENABLE = 3'd1;
    localparam logic [2:0] REG_TARGET_LOW   = 3'd2;
    localparam logic [2:0] REG_TARGET_HIGH  = 3'd3;
    localparam logic [2:0] REG_FIRE_MODES   = 3'd4;

    // Autofire mode codes
    localparam logic [MODE_W-1:0] FIRE_ALWAYS = 2'd0;
    localparam logic [MODE_W-1:0] FIRE_HALF   = 2'd1;
    localparam logic [MODE_W-1:0] FIRE_THIRD  = 2'd2;
    localparam logic [MODE_W-1:0] FIRE_FOURTH = 2'd3;

    // Per-lane mapping setup
    typedef struct packed {
        logic [TARGET_W-1:0] target;
        logic [MODE_W-1:0]   mode;
    } lane_cfg_t;

    // Control for the merge stage
    typedef struct packed {
        logic suppress;
        logic map_enable;
        logic chord;
    } merge_ctrl_t;

    // Autofire pattern for a mode code
    function automatic logic [KEY_W-1:0] fire_pattern(input logic [MODE_W-1:0] mode);
        logic [KEY_W-1:0] pat;
        case (mode)
            FIRE_ALWAYS: pat = 32'hffff_ffff;
            FIRE_HALF:   pat = 32'h5555_5555;
            FIRE_THIRD:  pat = 32'h4924_9249;
            FIRE_FOURTH: pat = 32'h1111_1111;
            default:     pat = 32'hffff_ffff;
        endcase
        return pat;
    endfunction

endpackage

[design/button_remap_with_autofire_unit.sv]
// ----------------------------------------------------------------------------
// button_remap_with_autofire_unit
// Controller poll remapper: 16 source lanes with autofire, stick decode,
// menu chord, APB register block and a skid-buffered output.
// ----------------------------------------------------------------------------
//  channel  | handshake            | payload
//  ---------+----------------------+------------------------------------------
//  in       | in_valid / in_stall  | buttons, stick_x, stick_y, suppress
//  out      | out_valid / out_stall| mapped_keys
//  config   | APB psel/penable     | paddr (8 * index), pwdata, prdata
//
//  One poll is accepted per cycle while in_stall is low; its result is
//  registered. All 16 lanes and the merge OR are combinational before the
//  output register; a one-beat skid keeps input open while out is stalled.
//  in_stall rises only when both output and skid hold a beat.
//  Reset (rst_n low, asynchronous) clears the poll counter, the registers
//  (stick_enable to 1) and all valid flags.
// ----------------------------------------------------------------------------
module button_remap_with_autofire_unit
    import brmap_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,

    input  logic                in_valid,
    output logic                in_stall,
    input  logic [BUTTON_W-1:0] buttons,
    input  logic [STICK_W-1:0]  stick_x,
    input  logic [STICK_W-1:0]  stick_y,
    input  logic                suppress,

    output logic                out_valid,
    input  logic                out_stall,
    output logic [KEY_W-1:0]    mapped_keys,

    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [5:0]          paddr,
    input  logic [63:0]         pwdata,
    output logic [63:0]         prdata,
    output logic                pready
);

    // Configuration registers
    logic        map_enable_reg;
    logic        stick_enable_reg;
    logic [39:0] target_low_reg;
    logic [39:0] target_high_reg;
    logic [31:0] fire_modes_reg;

    logic [2:0]  reg_idx;
    logic        cfg_wr;

    assign pready  = 1'b1;
    assign reg_idx = paddr[5:3];
    assign cfg_wr  = psel && penable && pwrite;

    // Write registers on the access beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_enable_reg   <= 1'b0;
            stick_enable_reg <= 1'b1;
            target_low_reg   <= '0;
            target_high_reg  <= '0;
            fire_modes_reg   <= '0;
        end
        else if (cfg_wr)
        begin
            case (reg_idx)
                REG_MAP_ENABLE:   map_enable_reg   <= pwdata[0];
                REG_STICK_ENABLE: stick_enable_reg <= pwdata[0];
                REG_TARGET_LOW:   target_low_reg   <= pwdata[39:0];
                REG_TARGET_HIGH:  target_high_reg  <= pwdata[39:0];
                REG_FIRE_MODES:   fire_modes_reg   <= pwdata[31:0];
                default: ;
            endcase
        end
    end

    // Read back
    always_comb
    begin
        case (reg_idx)
            REG_MAP_ENABLE:   prdata = {63'd0, map_enable_reg};
            REG_STICK_ENABLE: prdata = {63'd0, stick_enable_reg};
            REG_TARGET_LOW:   prdata = {24'd0, target_low_reg};
            REG_TARGET_HIGH:  prdata = {24'd0, target_high_reg};
            REG_FIRE_MODES:   prdata = {32'd0, fire_modes_reg};
            default:          prdata = '0;
        endcase
    end

    // Handshake and skid control
    logic             out_valid_reg;
    logic             skid_valid_reg;
    logic [KEY_W-1:0] out_keys_reg;
    logic [KEY_W-1:0] skid_keys_reg;
    logic             in_acc;
    logic             out_free;

    assign in_stall    = skid_valid_reg;
    assign in_acc      = in_valid && !skid_valid_reg;
    assign out_free    = !out_valid_reg || !out_stall;
    assign out_valid   = out_valid_reg;
    assign mapped_keys = out_keys_reg;

    // Poll counter: advance on every accepted poll that is not suppressed
    logic [COUNT_W-1:0] poll_cnt_reg;
    logic [COUNT_W-1:0] poll_cnt_next;

    assign poll_cnt_next = (in_acc && !suppress) ? poll_cnt_reg + 1'b1 : poll_cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            poll_cnt_reg <= '0;
        end
        else
        begin
            poll_cnt_reg <= poll_cnt_next;
        end
    end

    // Stick decode into virtual direction buttons
    logic [3:0] virt;

    always_comb
    begin
        virt = '0;
        if (stick_enable_reg)
        begin
            virt[0] = (stick_y < STICK_LOW);
            virt[2] = !(stick_y < STICK_LOW) && (stick_y > STICK_HIGH);
            virt[1] = (stick_x > STICK_HIGH);
            virt[3] = !(stick_x > STICK_HIGH) && (stick_x < STICK_LOW);
        end
    end

    // Source vector: digital dpad, virtual stick, face/trigger/system buttons
    logic [SOURCE_COUNT-1:0]            src_pressed;
    logic [SOURCE_COUNT-1:0][KEY_W-1:0] lane_hit;

    assign src_pressed = {buttons[11:4], virt, buttons[3:0]};

    // Lanes
    for (genvar i = 0; i < SOURCE_COUNT; i++)
    begin : g_lane
        lane_cfg_t lane_cfg;

        if (i < 8)
        begin : g_lo
            assign lane_cfg.target = target_low_reg[TARGET_W*i +: TARGET_W];
        end
        else
        begin : g_hi
            assign lane_cfg.target = target_high_reg[TARGET_W*(i-8) +: TARGET_W];
        end
        assign lane_cfg.mode = fire_modes_reg[MODE_W*i +: MODE_W];

        brmap_lane u_lane (
            .pressed  (src_pressed[i]),
            .cfg      (lane_cfg),
            .poll_cnt (poll_cnt_next),
            .hit      (lane_hit[i])
        );
    end

    // Merge lanes
    merge_ctrl_t      mctrl;
    logic [KEY_W-1:0] keys_next;

    assign mctrl.suppress   = suppress;
    assign mctrl.map_enable = map_enable_reg;
    assign mctrl.chord      = buttons[BTN_LTRIG] && buttons[BTN_SELECT];

    brmap_merge u_merge (
        .lane_hit (lane_hit),
        .ctrl     (mctrl),
        .keys     (keys_next)
    );

    // Output register and skid: drain skid first, park new beat when blocked
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg  <= skid_valid_reg || in_acc;
            skid_valid_reg <= 1'b0;
        end
        else if (in_acc)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            out_keys_reg <= skid_valid_reg ? skid_keys_reg : keys_next;
        end
        else if (in_acc)
        begin
            skid_keys_reg <= keys_next;
        end
    end

    // Assertions
    a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid holds a beat while output is empty");

    a_cnt_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && !suppress) |=> (poll_cnt_reg == COUNT_W'($past(poll_cnt_reg) + 1'b1)))
        else $error("poll counter did not advance");

    a_cnt_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_acc && !suppress) |=> $stable(poll_cnt_reg))
        else $error("poll counter moved without a counted poll");

    a_skid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && out_stall) |=> (skid_valid_reg && $stable(skid_keys_reg)))
        else $error("skid beat lost while output stalled");

endmodule

[design/brmap_lane.sv]
// ----------------------------------------------------------------------------
// brmap_lane
// One source lane: gates a pressed source by its autofire pattern and
// decodes its target index into a one-hot key word.
// ----------------------------------------------------------------------------
module brmap_lane
    import brmap_pkg::*;
(
    input  logic               pressed,
    input  lane_cfg_t          cfg,
    input  logic [COUNT_W-1:0] poll_cnt,
    output logic [KEY_W-1:0]   hit
);

    logic [KEY_W-1:0]   pat;
    logic [COUNT_W-1:0] bit_sel;
    logic               gate;

    // Pick pattern bit (31 - count), which is the inverted count
    assign pat     = fire_pattern(cfg.mode);
    assign bit_sel = ~poll_cnt;
    assign gate    = pat[bit_sel];

    // Decode target into one-hot
    always_comb
    begin
        hit = '0;
        if (pressed && gate)
        begin
            hit[cfg.target] = 1'b1;
        end
    end

endmodule

[design/brmap_merge.sv]
// ----------------------------------------------------------------------------
// brmap_merge
// Merge stage: ORs the lane words together and adds the menu chord bit.
// ----------------------------------------------------------------------------
module brmap_merge
    import brmap_pkg::*;
(
    input  logic [SOURCE_COUNT-1:0][KEY_W-1:0] lane_hit,
    input  merge_ctrl_t                        ctrl,
    output logic [KEY_W-1:0]                   keys
);

    logic [KEY_W-1:0] lane_or;

    // Combine lanes that may share a target
    always_comb
    begin
        lane_or = '0;
        for (int i = 0; i < SOURCE_COUNT; i++)
        begin
            lane_or = lane_or | lane_hit[i];
        end
    end

    // Apply enable, chord and suppression
    always_comb
    begin
        keys = ctrl.map_enable ? lane_or : '0;
        if (ctrl.chord)
        begin
            keys[MENU_BIT] = 1'b1;
        end
        if (ctrl.suppress)
        begin
            keys = '0;
        end
    end

endmodule

[tb/brmap_keys_checker.sv]
// ----------------------------------------------------------------------------
// brmap_keys_checker
// Watches the poll, key and register ports of the button remapper, predicts
// the key word for every accepted poll and compares it with the output beat.
// ----------------------------------------------------------------------------
module brmap_keys_checker
    import brmap_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,

    input  logic                in_valid,
    input  logic                in_stall,
    input  logic [BUTTON_W-1:0] buttons,
    input  logic [STICK_W-1:0]  stick_x,
    input  logic [STICK_W-1:0]  stick_y,
    input  logic                suppress,

    input  logic                out_valid,
    input  logic                out_stall,
    input  logic [KEY_W-1:0]    mapped_keys,

    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [5:0]          paddr,
    input  logic [63:0]         pwdata,
    input  logic                pready,

    output int                  fail_count,
    output int                  keys_pending,
    output int                  polls_seen,
    output int                  keys_checked
);

    // Shadow copy of the register block and the poll counter
    logic                map_en;
    logic                stick_en;
    logic [39:0]         tgt_lo;
    logic [39:0]         tgt_hi;
    logic [31:0]         fire_sel;
    logic [COUNT_W-1:0]  poll_cnt;

    // Key words still owed by the block, oldest first
    logic [KEY_W-1:0]    keys_due[$];

    // Autofire gate pattern for a 2-bit mode
    function automatic logic [KEY_W-1:0] autofire_mask(input logic [MODE_W-1:0] sel);
        case (sel)
            FIRE_HALF:   return 32'h5555_5555;
            FIRE_THIRD:  return 32'h4924_9249;
            FIRE_FOURTH: return 32'h1111_1111;
            default:     return 32'hffff_ffff;
        endcase
    endfunction

    // Work out the key word of one poll and advance the counter unless suppressed
    function automatic logic [KEY_W-1:0] predict_keys(
        input logic [BUTTON_W-1:0] btn,
        input logic [STICK_W-1:0]  sx,
        input logic [STICK_W-1:0]  sy,
        input logic                sup
    );
        logic [3:0]              virt;
        logic [SOURCE_COUNT-1:0] src;
        logic [KEY_W-1:0]        keys;
        logic [KEY_W-1:0]        pat;
        logic [TARGET_W-1:0]     tgt;
        virt = '0;
        keys = '0;
        if (sup)
            return '0;
        poll_cnt = poll_cnt + 1'b1;

        // Virtual stick directions: up wins over down, right over left
        if (stick_en)
        begin
            if (sy < STICK_LOW)
                virt[0] = 1'b1;
            else if (sy > STICK_HIGH)
                virt[2] = 1'b1;
            if (sx > STICK_HIGH)
                virt[1] = 1'b1;
            else if (sx < STICK_LOW)
                virt[3] = 1'b1;
        end
        src = {btn[BUTTON_W-1:4], virt, btn[3:0]};

        // Route each pressed source to its target, gated by autofire
        if (map_en)
        begin
            for (int i = 0; i < SOURCE_COUNT; i++)
            begin
                pat = autofire_mask(fire_sel[MODE_W*i +: MODE_W]);
                tgt = (i < 8) ? tgt_lo[TARGET_W*i +: TARGET_W]
                              : tgt_hi[TARGET_W*(i-8) +: TARGET_W];
                if (src[i] && pat[COUNT_W'(KEY_W - 1) - poll_cnt])
                    keys[tgt] = 1'b1;
            end
        end

        // Menu chord
        if (btn[BTN_LTRIG] && btn[BTN_SELECT])
            keys[MENU_BIT] = 1'b1;
        return keys;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        logic [KEY_W-1:0] want;
        if (!rst_n)
        begin
            map_en       = 1'b0;
            stick_en     = 1'b1;
            tgt_lo       = '0;
            tgt_hi       = '0;
            fire_sel     = '0;
            poll_cnt     = '0;
            keys_due.delete();
            fail_count   = 0;
            keys_pending = 0;
            polls_seen   = 0;
            keys_checked = 0;
        end
        else
        begin
            // Track register writes; unknown indexes are dropped
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[5:3])
                    REG_MAP_ENABLE:   map_en   = pwdata[0];
                    REG_STICK_ENABLE: stick_en = pwdata[0];
                    REG_TARGET_LOW:   tgt_lo   = pwdata[39:0];
                    REG_TARGET_HIGH:  tgt_hi   = pwdata[39:0];
                    REG_FIRE_MODES:   fire_sel = pwdata[31:0];
                    default: ;
                endcase
            end

            // Compare each output beat with the oldest prediction
            if (out_valid && !out_stall)
            begin
                if (keys_due.size() == 0)
                begin
                    $error("mapped_keys: unexpected beat, actual %h", mapped_keys);
                    fail_count++;
                end
                else
                begin
                    want = keys_due.pop_front();
                    keys_checked++;
                    if (mapped_keys !== want)
                    begin
                        $error("mapped_keys mismatch: expected %h, actual %h",
                               want, mapped_keys);
                        fail_count++;
                    end
                end
            end

            // Predict each accepted poll
            if (in_valid && !in_stall)
            begin
                keys_due.push_back(predict_keys(buttons, stick_x, stick_y, suppress));
                polls_seen++;
            end
            keys_pending = keys_due.size();
        end
    end

endmodule

[tb/tb_button_remap_with_autofire_unit.sv]
// ----------------------------------------------------------------------------
// tb_button_remap_with_autofire_unit
// Drives controller polls and register settings into the button remapper,
// with random idling on both channels; the key checker gives the verdict.
// ----------------------------------------------------------------------------
module tb_button_remap_with_autofire_unit;
    import brmap_pkg::*;

    localparam int         RANDOM_POLLS    = 240;
    localparam int         PHASE_COUNT     = 7;
    localparam int         LONG_HOLD       = 48;
    localparam int         WATCHDOG_LIMIT  = 5000;
    localparam logic [2:0] REG_SPARE_FIRST = 3'd5;
    localparam logic [2:0] REG_SPARE_LAST  = 3'd7;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    logic [BUTTON_W-1:0] buttons;
    logic [STICK_W-1:0]  stick_x;
    logic [STICK_W-1:0]  stick_y;
    logic                suppress;
    logic                out_valid;
    logic                out_stall;
    logic [KEY_W-1:0]    mapped_keys;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [5:0]          paddr;
    logic [63:0]         pwdata;
    logic [63:0]         prdata;
    logic                pready;

    int fail_count;
    int keys_pending;
    int polls_seen;
    int keys_checked;
    int send_idle_pct;
    int recv_idle_pct;
    int stuck_cycles;
    int settings_used;
    bit hold_out_long;

    button_remap_with_autofire_unit DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .buttons     (buttons),
        .stick_x     (stick_x),
        .stick_y     (stick_y),
        .suppress    (suppress),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .mapped_keys (mapped_keys),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    brmap_keys_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .buttons      (buttons),
        .stick_x      (stick_x),
        .stick_y      (stick_y),
        .suppress     (suppress),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .mapped_keys  (mapped_keys),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .pready       (pready),
        .fail_count   (fail_count),
        .keys_pending (keys_pending),
        .polls_seen   (polls_seen),
        .keys_checked (keys_checked)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Abort when no beat moves for too long
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            stuck_cycles = 0;
        else
            stuck_cycles++;
        if (stuck_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Watchdog: no beat for %0d cycles", WATCHDOG_LIMIT);
            $display("[button_remap_with_autofire_unit] ERROR");
            $finish;
        end
    end

    // Receiver: random stall bursts, plus one long hold on request
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_out_long)
            begin
                out_stall <= 1'b1;
                repeat (LONG_HOLD) @(negedge clk);
                hold_out_long = 1'b0;
                out_stall <= 1'b0;
            end
            else if ($urandom_range(0, 99) < recv_idle_pct)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 6)) @(negedge clk);
                out_stall <= 1'b0;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    // Offer one poll, with an optional gap first; returns at a falling edge
    task automatic send_poll(input logic [BUTTON_W-1:0] b, input logic [STICK_W-1:0] x,
                             input logic [STICK_W-1:0] y, input logic s);
        if ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
        in_valid <= 1'b1;
        buttons  <= b;
        stick_x  <= x;
        stick_y  <= y;
        suppress <= s;
        do
            @(posedge clk);
        while (in_stall);
        @(negedge clk);
    endtask

    // Drop valid and wait until every key word has come back
    task automatic drain_polls();
        in_valid <= 1'b0;
        while (keys_pending != 0)
            @(negedge clk);
        repeat (3) @(negedge clk);
    endtask

    // Register write: a setup phase, then an access phase
    task automatic reg_write(input logic [2:0] idx, input logic [63:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
    endtask

    task automatic apply_settings(input logic [63:0] map, input logic [63:0] stick,
                                  input logic [63:0] lo, input logic [63:0] hi,
                                  input logic [63:0] modes);
        reg_write(REG_MAP_ENABLE, map);
        reg_write(REG_STICK_ENABLE, stick);
        reg_write(REG_TARGET_LOW, lo);
        reg_write(REG_TARGET_HIGH, hi);
        reg_write(REG_FIRE_MODES, modes);
        settings_used++;
    endtask

    // Consecutive targets starting at first
    function automatic logic [63:0] pack_targets(input int first);
        logic [63:0] t;
        t = '0;
        for (int k = 0; k < 8; k++)
            t[TARGET_W*k +: TARGET_W] = TARGET_W'(first + k);
        return t;
    endfunction

    // Stick position biased toward the thresholds and the rails
    function automatic logic [STICK_W-1:0] pick_stick();
        case ($urandom_range(0, 3))
            0:       return STICK_W'(STICK_LOW - 1 + $urandom_range(0, 2));
            1:       return STICK_W'(STICK_HIGH - 1 + $urandom_range(0, 2));
            2:       return $urandom_range(0, 1) ? '1 : '0;
            default: return STICK_W'($urandom);
        endcase
    endfunction

    task automatic send_random_poll();
        logic [BUTTON_W-1:0] b;
        case ($urandom_range(0, 3))
            0:       b = BUTTON_W'(1) << $urandom_range(0, BUTTON_W-1);
            1:
            begin
                b = BUTTON_W'($urandom);
                b[BTN_LTRIG]  = 1'b1;
                b[BTN_SELECT] = 1'b1;
            end
            default: b = BUTTON_W'($urandom);
        endcase
        send_poll(b, pick_stick(), pick_stick(), $urandom_range(0, 9) == 0);
    endtask

    initial
    begin
        logic [BUTTON_W-1:0] chord;
        int                  phase;
        chord               = '0;
        chord[BTN_LTRIG]    = 1'b1;
        chord[BTN_SELECT]   = 1'b1;
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        buttons       = '0;
        stick_x       = 8'd128;
        stick_y       = 8'd128;
        suppress      = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        stuck_cycles  = 0;
        settings_used = 1;
        hold_out_long = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Reset settings: mapping off, so only the menu chord shows
        send_poll(chord, 8'd128, 8'd128, 1'b0);
        send_poll('1, 8'd0, 8'd255, 1'b0);
        send_poll(chord, 8'd128, 8'd128, 1'b1);
        drain_polls();

        // Identity mapping, autofire always on
        apply_settings(64'd1, 64'd1, pack_targets(0), pack_targets(8), 64'd0);
        send_poll('0, 8'd128, 8'd128, 1'b0);
        for (int k = 0; k < BUTTON_W; k++)
            send_poll(BUTTON_W'(1) << k, 8'd128, 8'd128, 1'b0);
        send_poll('1, 8'd128, 8'd128, 1'b0);
        send_poll('0, 8'd0, 8'd0, 1'b0);
        send_poll('0, 8'd255, 8'd255, 1'b0);
        send_poll('0, STICK_W'(STICK_LOW - 1), STICK_W'(STICK_HIGH + 1), 1'b0);
        send_poll('0, STICK_LOW, STICK_HIGH, 1'b0);
        send_poll('1, 8'd0, 8'd0, 1'b1);
        drain_polls();

        // Random phases, one register setting each
        for (phase = 0; phase < PHASE_COUNT; phase++)
        begin
            send_idle_pct = 20;
            recv_idle_pct = 20;
            case (phase)
                0:
                begin
                    apply_settings(64'd1, 64'd1, {$urandom, $urandom}, {$urandom, $urandom},
                                   64'($urandom));
                    hold_out_long = 1'b1;
                end
                1:
                begin
                    apply_settings(64'd1, 64'd0, 64'hff_ffff_ffff, 64'hff_ffff_ffff,
                                   64'hffff_ffff);
                    send_idle_pct = 0;
                    recv_idle_pct = 30;
                end
                2:
                begin
                    // All sources share target zero
                    apply_settings(64'd1, 64'd1, 64'd0, 64'd0, 64'h5555_5555);
                    send_idle_pct = 30;
                    recv_idle_pct = 0;
                end
                3:
                    apply_settings(64'd1, 64'd1, {$urandom, $urandom}, {$urandom, $urandom},
                                   64'haaaa_aaaa);
                4:
                    apply_settings(64'd0, 64'd1, {$urandom, $urandom}, {$urandom, $urandom},
                                   64'($urandom));
                5:
                begin
                    // Over-wide values get masked; spare indexes are ignored
                    apply_settings({$urandom, $urandom} | 64'd1, {$urandom, $urandom},
                                   {$urandom, $urandom}, {$urandom, $urandom},
                                   {$urandom, $urandom});
                    reg_write(3'($urandom_range(REG_SPARE_FIRST, REG_SPARE_LAST)),
                              {$urandom, $urandom});
                end
                default:
                begin
                    apply_settings(64'd1, 64'd1, {$urandom, $urandom}, {$urandom, $urandom},
                                   64'($urandom));
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            repeat (RANDOM_POLLS) send_random_poll();
            drain_polls();
        end

        repeat (5) @(negedge clk);
        $display("Summary: %0d polls sent and %0d key words checked over %0d settings.",
                 polls_seen, keys_checked, settings_used);
        $display("Covered stick edges, suppression, shared and extreme targets, every fire mode.");
        if (fail_count == 0)
            $display("[button_remap_with_autofire_unit] OK");
        else
            $display("[button_remap_with_autofire_unit] ERROR");
        $finish;
    end

endmodule
